FILE: hdl/occ_pkg.sv
`default_nettype none

package occ_pkg;

	typedef logic signed [15:0] coord_t;
	typedef logic [14:0]        radius_t;

	// opcode values of a request transaction
	localparam logic [1:0] OP_WRITE        = 2'd0;
	localparam logic [1:0] OP_QUERY_POINT  = 2'd1;
	localparam logic [1:0] OP_QUERY_CIRCLE = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_OBSTACLE_COUNT = 1'b0;

	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	// one obstacle table entry
	typedef struct packed {
		logic    rect;
		coord_t  ax;
		coord_t  ay;
		coord_t  bx;
		coord_t  by;
		radius_t radius;
	} entry_t;

	// query held for the length of a walk
	typedef struct packed {
		logic    is_circle;
		coord_t  qx;
		coord_t  qy;
		radius_t qr;
	} query_t;

	// tester pipeline status toward the controller
	typedef struct packed {
		logic busy;
		logic hit;
	} tst_status_t;

endpackage

`default_nettype wire

FILE: hdl/occ_if.sv
`default_nettype none

interface occ_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [5:0]          entry_index;
	logic                shape_kind;
	occ_pkg::coord_t     x_a;
	occ_pkg::coord_t     y_a;
	occ_pkg::coord_t     x_b;
	occ_pkg::coord_t     y_b;
	occ_pkg::radius_t    radius;

	modport source (
		output valid, opcode, entry_index, shape_kind, x_a, y_a, x_b, y_b, radius,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_index, shape_kind, x_a, y_a, x_b, y_b, radius,
		output ready
	);
endinterface

interface occ_rsp_if;
	logic valid;
	logic ready;
	logic feasible;

	modport source (
		output valid, feasible,
		input  ready
	);
	modport sink (
		input  valid, feasible,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/occ_ram.sv
`default_nettype none

module occ_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/occ_tester.sv
`default_nettype none

module occ_tester (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_valid,
	input  wire occ_pkg::entry_t      entry,
	input  wire occ_pkg::query_t      query,
	output      occ_pkg::tst_status_t status
);

	import occ_pkg::*;

	// s2: box bounds (a circle degenerates to its center) and radius sum
	coord_t            lx_d, rx_d, ly_d, ty_d;
	logic [15:0]       rs_d;

	logic              v_s2, rect_s2, dist_s2;
	coord_t            lx_s2, rx_s2, ly_s2, ty_s2;
	logic [15:0]       rs_s2;

	// s3: offset from the query center to the nearest point
	logic signed [16:0] qx_w, qy_w, lx_w, rx_w, ly_w, ty_w;
	logic               below_x, above_x, below_y, above_y;
	logic signed [16:0] dx_d, dy_d;

	logic               v_s3, in_box_s3, dist_s3;
	logic signed [16:0] dx_s3, dy_s3;
	logic [15:0]        rs_s3;

	// s4: squares
	logic signed [33:0] dx_sq, dy_sq;
	logic               v_s4, in_box_s4, dist_s4;
	logic [31:0]        dx2_s4, dy2_s4, rs2_s4;
	logic [32:0]        dist2;

	always_comb begin
		if (entry.rect) begin
			lx_d = (entry.ax < entry.bx) ? entry.ax : entry.bx;
			rx_d = (entry.ax < entry.bx) ? entry.bx : entry.ax;
			ly_d = (entry.ay < entry.by) ? entry.ay : entry.by;
			ty_d = (entry.ay < entry.by) ? entry.by : entry.ay;
			rs_d = {1'b0, query.qr};
		end else begin
			lx_d = entry.ax;
			rx_d = entry.ax;
			ly_d = entry.ay;
			ty_d = entry.ay;
			rs_d = {1'b0, entry.radius} + (query.is_circle ? {1'b0, query.qr} : 16'd0);
		end
	end

	always_comb begin
		qx_w    = {query.qx[15], query.qx};
		qy_w    = {query.qy[15], query.qy};
		lx_w    = {lx_s2[15], lx_s2};
		rx_w    = {rx_s2[15], rx_s2};
		ly_w    = {ly_s2[15], ly_s2};
		ty_w    = {ty_s2[15], ty_s2};
		below_x = qx_w < lx_w;
		above_x = qx_w > rx_w;
		below_y = qy_w < ly_w;
		above_y = qy_w > ty_w;
		dx_d    = below_x ? (qx_w - lx_w) : (above_x ? (qx_w - rx_w) : 17'sd0);
		dy_d    = below_y ? (qy_w - ly_w) : (above_y ? (qy_w - ty_w) : 17'sd0);
	end

	assign dx_sq = dx_s3 * dx_s3;
	assign dy_sq = dy_s3 * dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= rd_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		lx_s2     <= lx_d;
		rx_s2     <= rx_d;
		ly_s2     <= ly_d;
		ty_s2     <= ty_d;
		rs_s2     <= rs_d;
		rect_s2   <= entry.rect;
		dist_s2   <= !entry.rect || query.is_circle;

		dx_s3     <= dx_d;
		dy_s3     <= dy_d;
		rs_s3     <= rs_s2;
		in_box_s3 <= rect_s2 && !below_x && !above_x && !below_y && !above_y;
		dist_s3   <= dist_s2;

		// |d| <= 65535, so the square fits 32 bits
		dx2_s4    <= dx_sq[31:0];
		dy2_s4    <= dy_sq[31:0];
		rs2_s4    <= rs_s3 * rs_s3;
		in_box_s4 <= in_box_s3;
		dist_s4   <= dist_s3;
	end

	assign dist2 = {1'b0, dx2_s4} + {1'b0, dy2_s4};

	assign status.busy = v_s2 | v_s3 | v_s4;
	assign status.hit  = v_s4 & (in_box_s4 | (dist_s4 & (dist2 < {1'b0, rs2_s4})));

endmodule

`default_nettype wire

FILE: hdl/obstacle_set_collision_check.sv
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+------------------------------------------
// req      | in  | valid/ready         | opcode, entry_index, shape_kind,
//          |     |                     | x_a, y_a, x_b, y_b, radius
// rsp      | out | valid/ready         | feasible (one per query transaction)
// apb      | in  | psel/penable, pready| obstacle_count at byte address 0
//
// A write transaction goes straight into the table RAM.
// A query walks the table one entry per cycle through the single RAM read port:
// rsp is loaded once every issued read has passed the tester and rsp has room;
// an early hit stops issue, and the in-flight entries drain first.
// Reset clears the controller and obstacle_count; table contents are not
// cleared. A result waits in the output register while new transactions are
// taken; the walk only stalls at its end if rsp is still full.
`default_nettype none

module obstacle_set_collision_check #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	occ_req_if.sink          req,
	occ_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);

	import occ_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// control
	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      limit;
	logic               hit_q;
	logic               valid_s1_q;
	logic               rsp_valid_q;
	logic               feasible_q;
	query_t             qry_q;

	logic               req_acc;
	logic               idx_ok;
	logic               wr_en;
	logic               q_load;
	logic               issue;
	logic               rsp_load;
	logic               cfg_wr;

	entry_t             wr_entry;
	entry_t             rd_entry;
	tst_status_t        tst_status;

	// APB: pready tied high, register written in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OBSTACLE_COUNT);
	assign prdata = (paddr[2] == REG_OBSTACLE_COUNT) ? 32'(count_q) : 32'd0;

	// active entries, saturated to the table size
	assign limit = (32'(count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);
	assign idx_ok = 32'(req.entry_index) < 32'(TABLE_DEPTH);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign wr_entry = '{
		rect:   req.shape_kind,
		ax:     req.x_a,
		ay:     req.y_a,
		bx:     req.x_b,
		by:     req.y_b,
		radius: req.radius
	};

	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		q_load   = 1'b0;
		issue    = 1'b0;
		rsp_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					unique case (req.opcode) inside
						OP_WRITE: begin
							wr_en = idx_ok;
						end
						OP_QUERY_POINT, OP_QUERY_CIRCLE: begin
							q_load  = 1'b1;
							state_d = ST_WALK;
						end
						default: begin
							// unused opcode: dropped
						end
					endcase
				end
			end
			ST_WALK: begin
				if ((cnt_q < limit) && !hit_q) begin
					issue = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// every issued read has passed the tester and rsp has room
				if (!valid_s1_q && !tst_status.busy && (!rsp_valid_q || rsp.ready)) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			valid_s1_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			valid_s1_q <= issue;
			if (cfg_wr) begin
				count_q <= pwdata[COUNT_W-1:0];
			end
			if (q_load) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end
			if (q_load) begin
				hit_q <= 1'b0;
			end else if (tst_status.hit) begin
				hit_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_load) begin
			qry_q.is_circle <= (req.opcode == OP_QUERY_CIRCLE);
			qry_q.qx        <= req.x_a;
			qry_q.qy        <= req.y_a;
			qry_q.qr        <= req.radius;
		end
		if (rsp_load) begin
			feasible_q <= !hit_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.feasible = feasible_q;

	// obstacle table, one read per cycle during a walk
	occ_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(req.entry_index)),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rd_entry)
	);

	// per-entry collision test, three register stages after the RAM
	occ_tester u_tester (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (valid_s1_q),
		.entry    (rd_entry),
		.query    (qry_q),
		.status   (tst_status)
	);

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import occ_pkg::*;

	localparam int TABLE_DEPTH = 64;

	// opcode 3 has no meaning; the block must drop it without a response
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic SHAPE_CIRCLE = 1'b0;
	localparam logic SHAPE_RECT   = 1'b1;

	// per-side chance of a bubble, in percent
	localparam int GAP_PCT = 14;

	// receiver back-pressure: one long hold once enough responses have come
	localparam int HOLD_AFTER  = 80;
	localparam int HOLD_CYCLES = 400;

	// cycles to let a write or a dropped opcode finish before touching the register
	localparam int DRAIN_CYCLES = 12;

	// one request transaction as the driver sees it
	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] entry_index;
		logic       shape_kind;
		coord_t     x_a;
		coord_t     y_a;
		coord_t     x_b;
		coord_t     y_b;
		radius_t    radius;
	} request_t;

	logic clk = 1'b0;
	logic arst_n;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	occ_req_if req_ch();
	occ_rsp_if rsp_ch();

	obstacle_set_collision_check #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// shadow copy of the obstacle table and of obstacle_count
	entry_t     obstacle_table [TABLE_DEPTH];
	logic [6:0] active_count;

	request_t pending_requests[$];   // filled by the stimulus, drained by the driver
	logic     expected_free[$];      // one feasible bit per accepted query
	request_t offered;               // transaction currently on the request bus

	logic steady_flow;               // no bubbles on either side while set
	int   error_count;
	int   responses_seen;
	int   hold_left;
	logic hold_done;
	logic want_free;

	// append one transaction to the driver's queue
	task automatic add_request(request_t t);
		pending_requests.insert(pending_requests.size(), t);
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// everything the testbench drives has a known value from time zero
	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_WRITE;
		req_ch.entry_index = '0;
		req_ch.shape_kind  = SHAPE_CIRCLE;
		req_ch.x_a         = '0;
		req_ch.y_a         = '0;
		req_ch.x_b         = '0;
		req_ch.y_b         = '0;
		req_ch.radius      = '0;
		rsp_ch.ready       = 1'b0;
		steady_flow        = 1'b0;
		error_count        = 0;
		responses_seen     = 0;
		hold_left          = 0;
		hold_done          = 1'b0;
		active_count       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Collision predictor. All distances are compared squared, in 64-bit
	// integers, so nothing overflows even at the coordinate extremes.
	// ------------------------------------------------------------------
	function automatic logic obstacle_hits(entry_t ob, coord_t qx_c, coord_t qy_c,
			radius_t qr_c, logic is_circle);
		longint qx, qy, qr, ax, ay, bx, by;
		longint lx, rx, ly, ty, cx, cy, dx, dy, reach;
		qx = qx_c;
		qy = qy_c;
		qr = qr_c;
		ax = ob.ax;
		ay = ob.ay;
		if (ob.rect == SHAPE_CIRCLE) begin
			// point: strictly inside the circle; circle: overlap, touching is free
			dx    = qx - ax;
			dy    = qy - ay;
			reach = longint'(ob.radius) + (is_circle ? qr : 0);
			return (dx * dx + dy * dy) < (reach * reach);
		end
		bx = ob.bx;
		by = ob.by;
		// corners may come in either order
		lx = (ax < bx) ? ax : bx;
		rx = (ax < bx) ? bx : ax;
		ly = (ay < by) ? ay : by;
		ty = (ay < by) ? by : ay;
		// box bounds are inclusive
		if (lx <= qx && qx <= rx && ly <= qy && qy <= ty)
			return 1'b1;
		if (!is_circle)
			return 1'b0;
		// nearest point of the box to the circle center
		cx = (qx < lx) ? lx : ((qx > rx) ? rx : qx);
		cy = (qy < ly) ? ly : ((qy > ty) ? ty : qy);
		dx = qx - cx;
		dy = qy - cy;
		return (dx * dx + dy * dy) < (qr * qr);
	endfunction

	function automatic logic query_is_free(request_t t);
		int limit;
		// counts above the table depth saturate
		limit = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
		for (int e = 0; e < limit; e++)
			if (obstacle_hits(obstacle_table[e], t.x_a, t.y_a, t.radius,
					t.opcode == OP_QUERY_CIRCLE))
				return 1'b0;
		return 1'b1;
	endfunction

	// called once per accepted request transaction, in acceptance order
	task automatic predict_transaction(request_t t);
		case (t.opcode) inside
			OP_WRITE: begin
				obstacle_table[t.entry_index].rect   = t.shape_kind;
				obstacle_table[t.entry_index].ax     = t.x_a;
				obstacle_table[t.entry_index].ay     = t.y_a;
				obstacle_table[t.entry_index].bx     = t.x_b;
				obstacle_table[t.entry_index].by     = t.y_b;
				obstacle_table[t.entry_index].radius = t.radius;
			end
			OP_QUERY_POINT, OP_QUERY_CIRCLE: begin
				expected_free.insert(expected_free.size(), query_is_free(t));
			end
			default: begin
				// unused opcode: dropped, nothing to predict
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Request driver: holds a transaction until ready, then either offers
	// the next one from the queue or inserts a bubble.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_transaction(offered);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 &&
						(steady_flow || $urandom_range(99) >= GAP_PCT)) begin
					offered = pending_requests.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.opcode      <= offered.opcode;
					req_ch.entry_index <= offered.entry_index;
					req_ch.shape_kind  <= offered.shape_kind;
					req_ch.x_a         <= offered.x_a;
					req_ch.y_a         <= offered.y_a;
					req_ch.x_b         <= offered.x_b;
					req_ch.y_b         <= offered.y_b;
					req_ch.radius      <= offered.radius;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response monitor and ready generator. The long hold lets the output
	// register fill and the walk stall so the request side backs up.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_free.size() == 0) begin
					$display("%0t: response with no query outstanding: expected none, got %0b",
						$time, rsp_ch.feasible);
					error_count++;
				end else begin
					want_free = expected_free.pop_front();
					if (rsp_ch.feasible !== want_free) begin
						$display("%0t: feasible mismatch: expected %0b, got %0b",
							$time, want_free, rsp_ch.feasible);
						error_count++;
					end
				end
				responses_seen++;
			end
			if (!hold_done && responses_seen >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady_flow || $urandom_range(99) >= GAP_PCT;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(99);
		// mostly a crowded patch around the origin, some full range, some extremes
		if (pick < 75)
			return coord_t'(int'($urandom_range(6000)) - 3000);
		if (pick < 90)
			return coord_t'($urandom);
		case ($urandom_range(3))
			0:       return coord_t'(-32768);
			1:       return coord_t'(32767);
			2:       return coord_t'(0);
			default: return coord_t'(-1);
		endcase
	endfunction

	function automatic coord_t near_coord(coord_t base);
		return coord_t'(int'(base) + int'($urandom_range(1600)) - 800);
	endfunction

	function automatic radius_t rand_radius(int span);
		int pick;
		pick = $urandom_range(99);
		if (pick < 75)
			return radius_t'($urandom_range(span));
		if (pick < 90)
			return radius_t'($urandom);
		return ($urandom_range(1) != 0) ? radius_t'(32767) : radius_t'(0);
	endfunction

	function automatic request_t make_write(int idx, logic shape, int xa, int ya,
			int xb, int yb, int r);
		request_t t;
		t.opcode      = OP_WRITE;
		t.entry_index = 6'(idx);
		t.shape_kind  = shape;
		t.x_a         = coord_t'(xa);
		t.y_a         = coord_t'(ya);
		t.x_b         = coord_t'(xb);
		t.y_b         = coord_t'(yb);
		t.radius      = radius_t'(r);
		return t;
	endfunction

	// unused fields of a query still carry random bits
	function automatic request_t make_query(logic [1:0] op, int xa, int ya, int r);
		request_t t;
		t.opcode      = op;
		t.entry_index = 6'($urandom);
		t.shape_kind  = 1'($urandom);
		t.x_a         = coord_t'(xa);
		t.y_a         = coord_t'(ya);
		t.x_b         = coord_t'($urandom);
		t.y_b         = coord_t'($urandom);
		t.radius      = radius_t'(r);
		return t;
	endfunction

	function automatic request_t random_write(int idx);
		request_t t;
		t.opcode      = OP_WRITE;
		t.entry_index = 6'(idx);
		t.shape_kind  = 1'($urandom);
		t.x_a         = rand_coord();
		t.y_a         = rand_coord();
		// rectangles stay small most of the time so queries see both answers
		t.x_b         = (t.shape_kind == SHAPE_RECT) ? near_coord(t.x_a) : coord_t'($urandom);
		t.y_b         = (t.shape_kind == SHAPE_RECT) ? near_coord(t.y_a) : coord_t'($urandom);
		t.radius      = rand_radius(400);
		return t;
	endfunction

	function automatic request_t random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return random_write($urandom_range(TABLE_DEPTH - 1));
		if (pick < 60)
			return make_query(OP_QUERY_POINT, rand_coord(), rand_coord(), $urandom);
		if (pick < 95)
			return make_query(OP_QUERY_CIRCLE, rand_coord(), rand_coord(), rand_radius(600));
		return make_query(OP_UNUSED, rand_coord(), rand_coord(), $urandom);
	endfunction

	// sampled at the falling edge so the driver and monitor have settled
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_ch.valid || expected_free.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the
	// value at the edge that closes the access phase
	task automatic set_obstacle_count(input logic [6:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_OBSTACLE_COUNT, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		active_count = value;
	endtask

	task automatic run_random_phase(input logic [6:0] count, input int items,
			input logic no_gaps);
		set_obstacle_count(count);
		steady_flow = no_gaps;
		repeat (items) add_request(random_request());
		wait_quiet();
		steady_flow = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		wait (arst_n === 1'b1);
		wait_quiet();

		// empty active set: every query is free, the odd opcode is dropped
		set_obstacle_count(7'd0);
		add_request(make_query(OP_QUERY_POINT, -32768, 32767, 0));
		add_request(make_query(OP_QUERY_CIRCLE, 32767, -32768, 32767));
		add_request(make_query(OP_UNUSED, 0, 0, 0));
		// a small circle, a rectangle with swapped corners, a rectangle on the
		// negative edge of the grid, and a huge circle in the far corner
		add_request(make_write(0, SHAPE_CIRCLE, 0, 0, 0, 0, 10));
		add_request(make_write(1, SHAPE_RECT, 100, 100, 50, 50, 0));
		add_request(make_write(2, SHAPE_RECT, -32768, -32768, -32000, 32767, 32767));
		add_request(make_write(3, SHAPE_CIRCLE, 32767, 32767, -1, -1, 32767));
		wait_quiet();

		set_obstacle_count(7'd4);
		// point exactly on the circle edge is free, just inside is not
		add_request(make_query(OP_QUERY_POINT, 6, 8, 0));
		add_request(make_query(OP_QUERY_POINT, 6, 7, 0));
		// rectangle bounds are inclusive
		add_request(make_query(OP_QUERY_POINT, 50, 100, 0));
		add_request(make_query(OP_QUERY_POINT, 101, 75, 0));
		// two circles that only touch do not collide
		add_request(make_query(OP_QUERY_CIRCLE, 0, 20, 10));
		add_request(make_query(OP_QUERY_CIRCLE, 0, 19, 10));
		// circle against a box side through the clamp point
		add_request(make_query(OP_QUERY_CIRCLE, 120, 75, 20));
		add_request(make_query(OP_QUERY_CIRCLE, 120, 75, 21));
		// zero radius circle whose center sits on the box edge
		add_request(make_query(OP_QUERY_CIRCLE, -32768, 0, 0));
		add_request(make_query(OP_QUERY_POINT, 32767, 32767, 0));
		add_request(make_query(OP_QUERY_CIRCLE, 0, 0, 32767));
		add_request(make_query(OP_QUERY_POINT, -32768, -32768, 0));
		wait_quiet();

		// load every entry so any count is safe from here on
		for (int i = 0; i < TABLE_DEPTH; i++)
			add_request(random_write(i));
		wait_quiet();

		// the receiver hold lands inside the first, long phase
		run_random_phase(7'd64, 300, 1'b0);
		run_random_phase(7'd127, 60, 1'b1);
		run_random_phase(7'd1, 60, 1'b0);
		run_random_phase(7'd0, 40, 1'b0);
		run_random_phase(7'd65, 60, 1'b0);
		run_random_phase(7'd33, 60, 1'b0);
		run_random_phase(7'($urandom_range(2, 63)), 60, 1'b0);
		run_random_phase(7'd64, 60, 1'b0);

		repeat (20) @(posedge clk);
		if (expected_free.size() != 0) begin
			$display("%0t: responses missing: expected %0d more, got 0",
				$time, expected_free.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: obstacle_set_collision_check.f
hdl/occ_pkg.sv
hdl/occ_if.sv
hdl/occ_ram.sv
hdl/occ_tester.sv
hdl/obstacle_set_collision_check.sv
verif/testbench.sv
